>>> hw/rtl/xtea_pkg.sv
// Package for the pipelined XTEA block cipher: payload structs, register indexes,
// operation codes, reset constants and the half-round function.
// Depends on nothing; used by xtea_block_cipher.
package xtea_pkg;

  localparam int unsigned DefaultRounds = 32;
  localparam int unsigned WordW         = 32;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [WordW-1:0] DeltaReset = 32'h2E5673EA;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgKey0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKey1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKey2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKey3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDelta = 3'd4;

  // Operation codes.
  localparam logic OpDecrypt = 1'b0;
  localparam logic OpEncrypt = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [WordW-1:0] first_word;
    logic [WordW-1:0] second_word;
  } xtea_in_t;

  typedef struct packed {
    logic [WordW-1:0] out_first_word;
    logic [WordW-1:0] out_second_word;
  } xtea_out_t;

  // One item in flight: operation, both halves and the running sum.
  typedef struct packed {
    logic             op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] sum;
  } xtea_stage_t;

  typedef logic [3:0][WordW-1:0] xtea_key_t;

  function automatic logic [WordW-1:0] mix(logic [WordW-1:0] x);
    mix = ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // One half of a Feistel round. The first half updates the running sum, so the
  // second half always sees the sum that the round calls for.
  function automatic xtea_stage_t half_round(xtea_stage_t s, logic odd,
                                             xtea_key_t key, logic [WordW-1:0] delta);
    xtea_stage_t      r;
    logic [WordW-1:0] ka;
    logic [WordW-1:0] kb;
    logic [WordW-1:0] fa;
    logic [WordW-1:0] fb;
    r  = s;
    ka = s.sum + key[s.sum[1:0]];
    kb = s.sum + key[s.sum[12:11]];
    fa = mix(s.a) ^ kb;
    fb = mix(s.b) ^ ka;
    if (!odd) begin
      if (s.op == OpEncrypt) begin
        r.a   = s.a + fb;
        r.sum = s.sum + delta;
      end else begin
        r.b   = s.b - fa;
        r.sum = s.sum - delta;
      end
    end else begin
      if (s.op == OpEncrypt) begin
        r.b = s.b + fa;
      end else begin
        r.a = s.a - fb;
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/xtea_block_cipher.sv
// A block goes from input transfer to output valid through
// 2*ROUNDS+1 register stages; each stage after the entry stage holds one half-round.
// Throughput: one block per cycle while the output is not stalled.
// The entry stage registers the block with its starting sum (delta times ROUNDS
// for decryption); a stalled output with a block waiting holds every stage in place.
// Reset clears all valid bits and the keys, and sets the round delta to 0x2E5673EA.
// Top level of the pipelined XTEA cipher; depends on xtea_pkg.
module xtea_block_cipher #(
  parameter int unsigned ROUNDS = xtea_pkg::DefaultRounds
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xtea_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [xtea_pkg::WordW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  xtea_pkg::xtea_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output xtea_pkg::xtea_out_t           out_data_o
);

  localparam int unsigned Stages = 2 * ROUNDS;

  xtea_pkg::xtea_key_t           key_q;
  logic [xtea_pkg::WordW-1:0]    delta_q;

  logic                          vld_q [Stages+1];
  xtea_pkg::xtea_stage_t         dat_q [Stages+1];
  xtea_pkg::xtea_stage_t         dat_d [Stages+1];
  logic                          adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      delta_q <= xtea_pkg::DeltaReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        xtea_pkg::CfgKey0:  key_q[0] <= cfg_data_i;
        xtea_pkg::CfgKey1:  key_q[1] <= cfg_data_i;
        xtea_pkg::CfgKey2:  key_q[2] <= cfg_data_i;
        xtea_pkg::CfgKey3:  key_q[3] <= cfg_data_i;
        xtea_pkg::CfgDelta: delta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished block waits at the output.
  assign adv        = !(vld_q[Stages] && out_stall_i);
  assign in_stall_o = !adv;

  // Entry stage: the multiply by the round count is registered before any round.
  always_comb begin
    dat_d[0].op  = in_data_i.operation;
    dat_d[0].a   = in_data_i.first_word;
    dat_d[0].b   = in_data_i.second_word;
    dat_d[0].sum = (in_data_i.operation == xtea_pkg::OpEncrypt) ? '0 :
                   xtea_pkg::WordW'(delta_q * xtea_pkg::WordW'(ROUNDS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dat_q[0] <= dat_d[0];
    end
  end

  for (genvar j = 0; j < Stages; j++) begin : g_stage
    always_comb begin
      dat_d[j+1] = xtea_pkg::half_round(dat_q[j], 1'((j % 2) == 1), key_q, delta_q);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dat_q[j+1] <= dat_d[j+1];
      end
    end
  end

  assign out_valid_o                = vld_q[Stages];
  assign out_data_o.out_first_word  = dat_q[Stages].a;
  assign out_data_o.out_second_word = dat_q[Stages].b;

  // A stall is only ever raised while a finished block is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("input stalled with no block at the output");

  // An accepted transfer lands in the entry stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted block missing from the entry stage");

  // While stalled the first round stage keeps its occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_stall_o |=> $stable(vld_q[1]))
    else $error("pipeline moved during a stall");

  // Writes to other registers leave the round delta alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cfg_we_i && cfg_index_i != xtea_pkg::CfgDelta) |=> $stable(delta_q))
    else $error("round delta changed by a write to another register");

endmodule

>>> tb/xtea_block_cipher_tb.sv
// Self-checking testbench for the pipelined XTEA cipher: directed and random blocks under
// several key and delta settings, with random input gaps and output stalls.
// Depends on xtea_pkg and xtea_block_cipher.
`timescale 1ns / 100ps

module xtea_block_cipher_tb;
  import xtea_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 220;
  localparam int DrainCycles  = 2 * DefaultRounds + 16;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [WordW-1:0]   cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  xtea_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  xtea_out_t out_data_o;

  // Keeps its own copy of the key and delta, predicts each block and holds the
  // predictions in transfer order.
  class block_ledger;
    logic [WordW-1:0] key_words [4];
    logic [WordW-1:0] delta;
    xtea_out_t        awaited [$];
    int               failures;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      delta    = DeltaReset;
      failures = 0;
    endfunction

    function void load_register(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
      if (idx == CfgDelta) begin
        delta = data;
      end else if (idx < CfgDelta) begin
        key_words[idx[1:0]] = data;
      end
    endfunction

    function logic [WordW-1:0] scramble(logic [WordW-1:0] x);
      return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function xtea_out_t transform(xtea_in_t blk);
      logic [WordW-1:0] a;
      logic [WordW-1:0] b;
      logic [WordW-1:0] sum;
      xtea_out_t        res;
      a = blk.first_word;
      b = blk.second_word;
      if (blk.operation == OpEncrypt) begin
        sum = '0;
        for (int r = 0; r < DefaultRounds; r++) begin
          a   = a + (scramble(b) ^ (sum + key_words[sum[1:0]]));
          sum = sum + delta;
          b   = b + (scramble(a) ^ (sum + key_words[sum[12:11]]));
        end
      end else begin
        sum = delta * WordW'(DefaultRounds);
        for (int r = 0; r < DefaultRounds; r++) begin
          b   = b - (scramble(a) ^ (sum + key_words[sum[12:11]]));
          sum = sum - delta;
          a   = a - (scramble(b) ^ (sum + key_words[sum[1:0]]));
        end
      end
      res.out_first_word  = a;
      res.out_second_word = b;
      return res;
    endfunction

    function void note_block(xtea_in_t blk);
      awaited.push_back(transform(blk));
    endfunction

    function void check_block(xtea_out_t got);
      xtea_out_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected output block %h %h", got.out_first_word, got.out_second_word);
        return;
      end
      want = awaited.pop_front();
      if (got.out_first_word !== want.out_first_word ||
          got.out_second_word !== want.out_second_word) begin
        failures++;
        if (failures <= 10)
          $display("block mismatch: expected %h %h, got %h %h", want.out_first_word,
                   want.out_second_word, got.out_first_word, got.out_second_word);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  block_ledger ledger = new();

  bit        squeeze_req = 1'b0;
  bit        have_echo   = 1'b0;
  xtea_out_t echo_block;

  xtea_block_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Both transfers are observed with the values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) ledger.note_block(in_data_i);
      if (out_valid_o && !out_stall_i) ledger.check_block(out_data_o);
    end
  end

  // Receiver: stall patterns in segments, plus one long hold-off on request.
  initial begin : receiver
    int mode;
    int span;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      for (int c = 0; c < span; c++) begin
        @(posedge clk_i);
        if (squeeze_req) begin
          squeeze_req = 1'b0;
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
        end else begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 3) == 0);
            2:       out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= c[0];
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("xtea_block_cipher_tb NOT OK");
    $finish;
  end

  task automatic send_block(xtea_in_t blk);
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    ledger.load_register(idx, data);
    @(posedge clk_i);
  endtask

  // Writes the whole register set, then a random index beyond the last register,
  // which the block must ignore.
  task automatic program_setting(logic [WordW-1:0] k0, logic [WordW-1:0] k1,
                                 logic [WordW-1:0] k2, logic [WordW-1:0] k3,
                                 logic [WordW-1:0] d);
    write_reg(CfgKey0, k0);
    write_reg(CfgKey1, k1);
    write_reg(CfgKey2, k2);
    write_reg(CfgKey3, k3);
    write_reg(CfgDelta, d);
    write_reg(CfgDelta + CfgIdxW'($urandom_range(1, 3)), $urandom);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ledger.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [WordW-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly fresh blocks; now and then the predicted ciphertext of an earlier
  // block is fed back for decryption.
  function automatic xtea_in_t random_block();
    xtea_in_t blk;
    if (have_echo && $urandom_range(0, 3) == 0) begin
      blk.operation   = OpDecrypt;
      blk.first_word  = echo_block.out_first_word;
      blk.second_word = echo_block.out_second_word;
      have_echo       = 1'b0;
    end else begin
      blk.operation   = $urandom_range(0, 1) ? OpEncrypt : OpDecrypt;
      blk.first_word  = random_word();
      blk.second_word = random_word();
      if (blk.operation == OpEncrypt) begin
        echo_block = ledger.transform(blk);
        have_echo  = 1'b1;
      end
    end
    return blk;
  endfunction

  task automatic run_random(int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_block(random_block());
        left--;
      end
      if (gap > 0) pause_sender(gap);
    end
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [2*WordW-1:0] directed_pair(int idx);
    case (idx)
      0:       return {32'h0000_0000, 32'h0000_0000};
      1:       return {32'hFFFF_FFFF, 32'hFFFF_FFFF};
      2:       return {32'h0000_0000, 32'hFFFF_FFFF};
      3:       return {32'hFFFF_FFFF, 32'h0000_0000};
      4:       return {32'hAAAA_AAAA, 32'h5555_5555};
      5:       return {32'h5555_5555, 32'hAAAA_AAAA};
      6:       return {32'h8000_0000, 32'h0000_0001};
      7:       return {32'h0000_0001, 32'h8000_0000};
      8:       return {32'h0123_4567, 32'h89AB_CDEF};
      default: return {32'h0F0F_0F0F, 32'hF0F0_F0F0};
    endcase
  endfunction

  initial begin : stimulus
    xtea_in_t blk;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CfgKey0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes and both operations under the reset key and delta.
    for (int i = 0; i < 20; i++) begin
      blk.operation = (i % 2 == 0) ? OpEncrypt : OpDecrypt;
      {blk.first_word, blk.second_word} = directed_pair(i / 2);
      send_block(blk);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    run_random(60);
    wait_drained();

    // Zero delta: the running sum never moves.
    program_setting('0, '0, '0, '0, '0);
    run_random(65);
    wait_drained();

    program_setting('1, '1, '1, '1, '1);
    run_random(65);
    wait_drained();

    program_setting($urandom, $urandom, $urandom, $urandom, 32'h9E37_79B9);
    squeeze_req = 1'b1;
    run_random(65);
    wait_drained();

    program_setting($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(65);
    wait_drained();

    program_setting('0, '1, $urandom, '1, 32'h0000_0001);
    run_random(65);
    wait_drained();

    program_setting($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(65);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("xtea_block_cipher_tb OK");
    end else begin
      $display("xtea_block_cipher_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/xtea_pkg.sv
hw/rtl/xtea_block_cipher.sv
tb/xtea_block_cipher_tb.sv
